### hw/rtl/mrls_pkg.sv
`timescale 1ns / 1ps

package mrls_pkg;

	localparam int SlotsDefault = 12;

	localparam int CountW = 10;
	localparam int SlotW  = 4;
	localparam int LevelW = 8;
	localparam int AnodeW = 12;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_RAINBOW = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_PWM_PERIOD = 2'd0,
		REG_SCAN_POINT = 2'd1,
		REG_NUM_SLOTS  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	localparam logic [CountW-1:0] PwmPeriodReset = 10'h265;
	localparam logic [CountW-1:0] ScanPointReset = 10'h100;
	localparam logic [SlotW-1:0]  NumSlotsReset  = 4'd12;

	localparam logic [LevelW-1:0] RedStart   = 8'h00;
	localparam logic [LevelW-1:0] GreenStart = 8'h55;
	localparam logic [LevelW-1:0] BlueStart  = 8'h99;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic              down;
	} bounce_t;

	function automatic bounce_t bounce_step(input logic [LevelW-1:0] level, input logic down);
		bounce_t           r;
		logic [LevelW-1:0] v;
		logic              d;
		d = down;
		v = d ? level - 8'd1 : level + 8'd1;
		if (v == '0) begin
			d = ~d;
			v = d ? v - 8'd1 : v + 8'd1;
		end
		r.level = v;
		r.down  = d;
		return r;
	endfunction

endpackage

### hw/rtl/multiplexed_rgb_led_scanner.sv
`timescale 1ns / 1ps
// an accepted input transaction becomes its output transaction in the next cycle
// throughput: one transaction per cycle while the output stream is not stalled; the color table is a one-port-write,
// one-port-read memory with registered read data and same-entry write forwarding
// reset: arst_n clears counter, active slot, rainbow directions and all table valid bits
// (no clearing pass), and loads the rainbow levels and configuration registers with their defaults
module multiplexed_rgb_led_scanner #(
	parameter int SLOTS = mrls_pkg::SlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // slot_number[3:0], red_level[11:4], green_level[19:12], blue_level[27:20], zero
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // anode_select[11:0], red_on[12], green_on[13], blue_on[14], zero
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = 3 * mrls_pkg::LevelW;
	localparam logic [4:0] SlotsW5 = 5'(SLOTS);

	logic [mrls_pkg::CountW-1:0] pwm_period_q, scan_point_q;
	logic [mrls_pkg::SlotW-1:0]  num_slots_q;

	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= mrls_pkg::PwmPeriodReset;
			scan_point_q <= mrls_pkg::ScanPointReset;
			num_slots_q  <= mrls_pkg::NumSlotsReset;
		end else if (cfg_we) begin
			case (mrls_pkg::reg_idx_t'(paddr[3:2]))
				mrls_pkg::REG_PWM_PERIOD: pwm_period_q <= pwdata[mrls_pkg::CountW-1:0];
				mrls_pkg::REG_SCAN_POINT: scan_point_q <= pwdata[mrls_pkg::CountW-1:0];
				mrls_pkg::REG_NUM_SLOTS:  num_slots_q  <= pwdata[mrls_pkg::SlotW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (mrls_pkg::reg_idx_t'(paddr[3:2]))
			mrls_pkg::REG_PWM_PERIOD: prdata = 32'(pwm_period_q);
			mrls_pkg::REG_SCAN_POINT: prdata = 32'(scan_point_q);
			mrls_pkg::REG_NUM_SLOTS:  prdata = 32'(num_slots_q);
			default:                  prdata = '0;
		endcase
	end

	// input fields
	mrls_pkg::req_t              req;
	logic [mrls_pkg::SlotW-1:0]  slot_number;
	logic [mrls_pkg::LevelW-1:0] red_level, green_level, blue_level;
	assign req         = mrls_pkg::req_t'(s_axis_tuser);
	assign slot_number = s_axis_tdata[3:0];
	assign red_level   = s_axis_tdata[11:4];
	assign green_level = s_axis_tdata[19:12];
	assign blue_level  = s_axis_tdata[27:20];

	logic accept;
	logic m_valid_q;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (s_axis_tready) m_valid_q <= s_axis_tvalid;
	end
	assign m_axis_tvalid = m_valid_q;

	// counter and slot state
	logic [mrls_pkg::CountW-1:0] pwm_count_q, pwm_next;
	logic [mrls_pkg::SlotW-1:0]  active_slot_q, slot_next;
	logic [4:0]                  slot_limit, slot_inc;

	always_comb begin
		if (num_slots_q == '0) slot_limit = 5'd1;
		else if (5'(num_slots_q) > SlotsW5) slot_limit = SlotsW5;
		else slot_limit = 5'(num_slots_q);

		pwm_next  = pwm_count_q;
		slot_next = active_slot_q;
		slot_inc  = 5'(active_slot_q) + 5'd1;
		if (req == mrls_pkg::REQ_TICK) begin
			pwm_next = (pwm_count_q >= pwm_period_q) ? '0 : pwm_count_q + 10'd1;
			if (pwm_next == scan_point_q)
				slot_next = (slot_inc >= slot_limit) ? '0 : slot_inc[mrls_pkg::SlotW-1:0];
		end
	end

	// rainbow state
	mrls_pkg::bounce_t bn_r, bn_g, bn_b;
	logic [mrls_pkg::LevelW-1:0] rb_red_q, rb_green_q, rb_blue_q;
	logic [2:0] rb_down_q;

	assign bn_r = mrls_pkg::bounce_step(rb_red_q, rb_down_q[0]);
	assign bn_g = mrls_pkg::bounce_step(rb_green_q, rb_down_q[1]);
	assign bn_b = mrls_pkg::bounce_step(rb_blue_q, rb_down_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_count_q   <= '0;
			active_slot_q <= '0;
			rb_red_q      <= mrls_pkg::RedStart;
			rb_green_q    <= mrls_pkg::GreenStart;
			rb_blue_q     <= mrls_pkg::BlueStart;
			rb_down_q     <= '0;
		end else if (accept) begin
			pwm_count_q   <= pwm_next;
			active_slot_q <= slot_next;
			if (req == mrls_pkg::REQ_RAINBOW) begin
				rb_red_q   <= bn_r.level;
				rb_green_q <= bn_g.level;
				rb_blue_q  <= bn_b.level;
				rb_down_q  <= {bn_b.down, bn_g.down, bn_r.down};
			end
		end
	end

	// color table write side
	logic          tbl_we;
	logic [IW-1:0] tbl_waddr, tbl_raddr;
	logic [EW-1:0] tbl_wdata;
	logic [mrls_pkg::SlotW-1:0] slot_index;

	assign slot_index = slot_number - 4'd1;
	assign tbl_raddr  = slot_next[IW-1:0];

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = slot_index[IW-1:0];
		tbl_wdata = {blue_level, green_level, red_level};
		case (req)
			mrls_pkg::REQ_WRITE: begin
				tbl_we = accept && (slot_number != '0) && (5'(slot_number) <= SlotsW5);
			end
			mrls_pkg::REQ_RAINBOW: begin
				tbl_we    = accept;
				tbl_waddr = IW'(SLOTS - 1);
				tbl_wdata = {bn_b.level, bn_g.level, bn_r.level};
			end
			default: ;
		endcase
	end

	logic [EW-1:0]    color_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [EW-1:0]    rdata_s1, wdata_s1;
	logic             rvalid_s1, fwd_s1;

	always_ff @(posedge clk) begin
		if (tbl_we) color_mem[tbl_waddr] <= tbl_wdata;
		if (accept) begin
			rdata_s1 <= color_mem[tbl_raddr];
			wdata_s1 <= tbl_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (tbl_we) valid_q[tbl_waddr] <= 1'b1;
			if (accept) begin
				rvalid_s1 <= valid_q[tbl_raddr];
				fwd_s1    <= tbl_we && (tbl_waddr == tbl_raddr);
			end
		end
	end

	// output
	logic [EW-1:0] level;
	logic [mrls_pkg::AnodeW-1:0] anode_select;
	logic red_on, green_on, blue_on;

	always_comb begin
		if (fwd_s1) level = wdata_s1;
		else if (rvalid_s1) level = rdata_s1;
		else level = '0;
		anode_select = (active_slot_q < 4'd12) ?
			(mrls_pkg::AnodeW'(1) << active_slot_q) : '0;
		red_on   = pwm_count_q < 10'(level[7:0]);
		green_on = pwm_count_q < 10'(level[15:8]);
		blue_on  = pwm_count_q < 10'(level[23:16]);
	end

	assign m_axis_tdata = {1'b0, blue_on, green_on, red_on, anode_select};

	// checks
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		5'(active_slot_q) < SlotsW5)
		else $error("active slot out of range");

	a_anode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(anode_select))
		else $error("anode select not one-hot");

	a_count_moves_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pwm_count_q) |-> $past(accept && (req == mrls_pkg::REQ_TICK)))
		else $error("pwm counter moved without a tick");

	a_table_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> accept && (req == mrls_pkg::REQ_WRITE || req == mrls_pkg::REQ_RAINBOW))
		else $error("table written without a transaction");

	a_valid_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(accept))
		else $error("output valid without an accepted transaction");

endmodule
